// ===== hdl/wgts_pkg.sv =====
// Shared types and constants of the wind grid trilinear sampler.
`default_nettype none
package wgts_pkg;
  localparam int GridX = 16;
  localparam int GridY = 16;
  localparam int GridZ = 16;
  localparam int XW = $clog2(GridX);
  localparam int YW = $clog2(GridY);
  localparam int ZW = $clog2(GridZ);
  localparam int AW = XW + YW + ZW;
  localparam int CellCount = GridX * GridY * GridZ;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_INTERP = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_SPACING_X = 3'd3;
  localparam logic [2:0] REG_SPACING_Y = 3'd4;
  localparam logic [2:0] REG_SPACING_Z = 3'd5;

  // Quotient width: |d| < 2^33, times 2^16 over spacing >= 1.
  localparam int QW = 50;
  localparam int NW = 49; // numerator magnitude width

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_READ, ST_READ_WAIT, ST_READ_OUT,
    ST_DIV, ST_DIV_WAIT, ST_CORNER, ST_DRAIN, ST_ROUND, ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;      // capture request
    logic       wr;        // write memory
    logic       rd_cell;   // read cell address
    logic       div_start; // start divider on axis
    logic [1:0] div_axis;
    logic       corner;    // issue corner read
    logic       acc_clr;
    logic       finish;    // sum to result
    logic       out_read;  // present read data
    logic       out_interp;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       last_corner;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/wind_grid_trilinear_sampler_core.sv =====
// Top level of the wind grid trilinear sampler.
// A read passes the read, wait and output states before the result strobe; interpolate
// runs three passes of one shared 49-step radix-2 divider, 8 corner reads, a drain,
// then round, present and strobe; a write passes through the single write state.
// One request at a time; busy is high until the strobe cycle, which may accept the next.
// Reset (rst_ni, asynchronous, low) clears control, origin 0, spacing 1.0; grid undefined.
`default_nettype none
module wind_grid_trilinear_sampler_core import wgts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    valid_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [1:0]         func_i,
  input  wire logic [3:0]         cell_x_i,
  input  wire logic [3:0]         cell_y_i,
  input  wire logic [3:0]         cell_z_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] data_x_i,
  input  wire logic signed [15:0] data_y_i,
  input  wire logic signed [15:0] data_z_i,
  output logic signed [15:0]      wind_x_o,
  output logic signed [15:0]      wind_y_o,
  output logic signed [15:0]      wind_z_o
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wgts_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i, .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .valid_o
  );

  wgts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cell_x_i, .cell_y_i, .cell_z_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .data_x_i, .data_y_i, .data_z_i, .wind_x_o, .wind_y_o, .wind_z_o
  );

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_WRITE) |=> busy) else $error("write not taken");
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result while busy");
`endif
endmodule
`default_nettype wire

// ===== hdl/wgts_div.sv =====
// Radix-2 restoring divider for the grid coordinate, one bit per cycle.
`default_nettype none
module wgts_div import wgts_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [30:0]   den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o,
  output logic               rem_nz_o
);
  logic [NW-1:0] quo_q, quo_d;
  logic [31:0]   rem_q, rem_d;
  logic [30:0]   den_q, den_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [31:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[30:0], quo_q[NW-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 6'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;
endmodule
`default_nettype wire

// ===== hdl/wgts_datapath.sv =====
// Datapath: registers, grid memory, divider and corner blend.
`default_nettype none
module wgts_datapath import wgts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [3:0]         cell_x_i,
  input  wire logic [3:0]         cell_y_i,
  input  wire logic [3:0]         cell_z_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] data_x_i,
  input  wire logic signed [15:0] data_y_i,
  input  wire logic signed [15:0] data_z_i,
  output logic signed [15:0]      wind_x_o,
  output logic signed [15:0]      wind_y_o,
  output logic signed [15:0]      wind_z_o
);
  logic signed [31:0] origin_q [3];
  logic [30:0]        spacing_q [3];
  logic [3:0]  cx_q, cy_q, cz_q;
  logic        cin_q;
  logic signed [31:0] pos_q [3];
  logic [47:0] wdata_q;
  logic [47:0] mem [CellCount];
  logic [47:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        origin_q[k]  <= '0;
        spacing_q[k] <= 31'd65536;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:  origin_q[0]  <= cfg_data_i;
        REG_ORIGIN_Y:  origin_q[1]  <= cfg_data_i;
        REG_ORIGIN_Z:  origin_q[2]  <= cfg_data_i;
        REG_SPACING_X: spacing_q[0] <= cfg_data_i[30:0];
        REG_SPACING_Y: spacing_q[1] <= cfg_data_i[30:0];
        REG_SPACING_Z: spacing_q[2] <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= cell_x_i; cy_q <= cell_y_i; cz_q <= cell_z_i;
      cin_q <= (32'(cell_x_i) < GridX) && (32'(cell_y_i) < GridY) &&
               (32'(cell_z_i) < GridZ);
      pos_q[0] <= pos_x_i; pos_q[1] <= pos_y_i; pos_q[2] <= pos_z_i;
      wdata_q <= {data_z_i, data_y_i, data_x_i};
    end
  end

  // Divider: per-axis signed floor of (d*65536)/s.
  logic signed [32:0] dlt;
  logic [32:0]        dmag;
  logic               dneg_q [3];
  logic [NW-1:0]      quo;
  logic               rem_nz, div_done;
  logic [30:0]        sp;
  logic [1:0]         ax_q;

  assign dlt  = 33'(pos_q[cmd_i.div_axis]) - 33'(origin_q[cmd_i.div_axis]);
  assign dmag = dlt[32] ? 33'(-dlt) : 33'(dlt);
  assign sp   = (spacing_q[cmd_i.div_axis] == '0) ? 31'd1 : spacing_q[cmd_i.div_axis];

  wgts_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .num_i({dmag[32:0], 16'd0}), .den_i(sp),
    .done_o(div_done), .quo_o(quo), .rem_nz_o(rem_nz)
  );

  logic signed [QW-1:0] g;
  logic signed [QW-1:0] base_q [3];
  logic [15:0]          frac_q [3];
  always_comb begin
    if (dneg_q[ax_q]) g = -$signed(QW'(quo)) - QW'(rem_nz);
    else              g = $signed(QW'(quo));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      ax_q <= cmd_i.div_axis;
      dneg_q[cmd_i.div_axis] <= dlt[32];
    end
    if (div_done) begin
      base_q[ax_q] <= g >>> 16;
      frac_q[ax_q] <= g[15:0];
    end
  end

  // Corner sequencing.
  logic [2:0] c_q;
  logic [16:0] wsel [3];
  logic signed [QW-1:0] crd [3];
  logic       c_in;
  logic [AW-1:0] caddr;
  logic [16:0] w_q, wz_q, wxy;
  logic [33:0] prod1;
  logic [33:0] prod2;
  logic       p_v_q, m_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic ob;
      ob = (k == 0) ? c_q[2] : (k == 1) ? c_q[1] : c_q[0];
      wsel[k] = ob ? {1'b0, frac_q[k]} : (17'd65536 - {1'b0, frac_q[k]});
      crd[k]  = base_q[k] + QW'(ob);
    end
    c_in = (crd[0] >= 0) && (crd[0] < GridX) && (crd[1] >= 0) && (crd[1] < GridY) &&
           (crd[2] >= 0) && (crd[2] < GridZ);
    caddr = {crd[2][ZW-1:0], crd[1][YW-1:0], crd[0][XW-1:0]};
    prod1 = wsel[0] * wsel[1];
    wxy   = prod1[32:16];
    prod2 = w_q * wz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0; p_v_q <= 1'b0; m_v_q <= 1'b0;
    end else begin
      if (cmd_i.acc_clr) c_q <= '0;
      else if (cmd_i.corner) c_q <= c_q + 3'd1;
      p_v_q <= cmd_i.corner && c_in;
      m_v_q <= p_v_q;
    end
  end
  assign sts_o.last_corner = (c_q == 3'd7);
  assign sts_o.div_done = div_done;

  // Memory port: one read and at most one write per cycle.
  logic [AW-1:0] raddr;
  assign raddr = cmd_i.rd_cell ? {cz_q[ZW-1:0], cy_q[YW-1:0], cx_q[XW-1:0]} : caddr;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && cin_q)
      mem[{cz_q[ZW-1:0], cy_q[YW-1:0], cx_q[XW-1:0]}] <= wdata_q;
    rdata_q <= mem[raddr];
  end

  // Delay corner data one stage to line up with its final weight.
  logic [47:0] md_q;
  logic [16:0] w2_q;
  logic signed [47:0] acc_q [3];
  always_ff @(posedge clk_i) begin
    w_q  <= wxy;
    wz_q <= wsel[2];
    w2_q <= prod2[32:16];
    md_q <= rdata_q;
    if (cmd_i.acc_clr) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else if (m_v_q) begin
      for (int k = 0; k < 3; k++)
        acc_q[k] <= acc_q[k] + 48'($signed(md_q[16*k +: 16]) * $signed({1'b0, w2_q}));
    end
  end

  logic signed [15:0] res_q [3];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [31:0] s;
      s = acc_q[k][47:16];
      if (cmd_i.finish)
        res_q[k] <= (s > 32767) ? 16'sd32767 : (s < -32768) ? -16'sd32768 : s[15:0];
      else if (cmd_i.out_read)
        res_q[k] <= cin_q ? rdata_q[16*k +: 16] : 16'sd0;
    end
  end
  assign wind_x_o = res_q[0];
  assign wind_y_o = res_q[1];
  assign wind_z_o = res_q[2];
endmodule
`default_nettype wire

// ===== hdl/wgts_ctrl.sv =====
// Controller state machine of the sampler.
`default_nettype none
module wgts_ctrl import wgts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] func_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o,
  output logic            busy_o,
  output logic            valid_o
);
  state_e st_q, st_d;
  logic [1:0] ax_q, ax_d;
  logic [2:0] dr_q, dr_d;
  logic v_q, v_d;

  always_comb begin
    st_d = st_q; ax_d = ax_q; dr_d = dr_q;
    case (st_q)
      ST_IDLE:
        if (start_i) begin
          case (func_i)
            FUNC_WRITE:  st_d = ST_WRITE;
            FUNC_READ:   st_d = ST_READ;
            FUNC_INTERP: begin st_d = ST_DIV; ax_d = 2'd0; end
            default:     st_d = ST_IDLE;
          endcase
        end
      ST_WRITE:     st_d = ST_IDLE;
      ST_READ:      st_d = ST_READ_WAIT;
      ST_READ_WAIT: st_d = ST_READ_OUT;
      ST_READ_OUT:  st_d = ST_IDLE;
      ST_DIV:       st_d = ST_DIV_WAIT;
      ST_DIV_WAIT:
        if (sts_i.div_done) begin
          if (ax_q == 2'd2) st_d = ST_CORNER;
          else begin ax_d = ax_q + 2'd1; st_d = ST_DIV; end
        end
      ST_CORNER:
        if (sts_i.last_corner) begin st_d = ST_DRAIN; dr_d = 3'd4; end
      ST_DRAIN: begin
        dr_d = dr_q - 3'd1;
        if (dr_q == 3'd1) st_d = ST_ROUND;
      end
      ST_ROUND: st_d = ST_OUT;
      ST_OUT:   st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_axis = ax_q;
    v_d = 1'b0;
    case (st_q)
      ST_IDLE:      begin cmd_o.load = start_i; cmd_o.acc_clr = 1'b1; end
      ST_WRITE:     cmd_o.wr = 1'b1;
      ST_READ:      cmd_o.rd_cell = 1'b1;
      // hold the cell address so the read data is still valid in ST_READ_OUT
      ST_READ_WAIT: cmd_o.rd_cell = 1'b1;
      ST_READ_OUT:  begin cmd_o.out_read = 1'b1; v_d = 1'b1; end
      ST_DIV:       cmd_o.div_start = 1'b1;
      ST_CORNER:    cmd_o.corner = 1'b1;
      ST_ROUND:     cmd_o.finish = 1'b1;
      ST_OUT:       begin cmd_o.out_interp = 1'b1; v_d = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ax_q <= '0; dr_q <= '0; v_q <= 1'b0;
    end else begin
      st_q <= st_d; ax_q <= ax_d; dr_q <= dr_d; v_q <= v_d;
    end
  end

  assign busy_o  = (st_q != ST_IDLE);
  assign valid_o = v_q;
endmodule
`default_nettype wire

// ===== tb/sv/wgts_checker.sv =====
// Checker for the wind grid sampler: tracks requests, predicts wind vectors, compares results.
`default_nettype none
module wgts_checker import wgts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic               valid_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [1:0]         func_i,
  input  wire logic [3:0]         cell_x_i,
  input  wire logic [3:0]         cell_y_i,
  input  wire logic [3:0]         cell_z_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] data_x_i,
  input  wire logic signed [15:0] data_y_i,
  input  wire logic signed [15:0] data_z_i,
  input  wire logic signed [15:0] wind_x_i,
  input  wire logic signed [15:0] wind_y_i,
  input  wire logic signed [15:0] wind_z_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } wind_t;

  wind_t       grid_mem [CellCount];
  longint      origin [3];
  longint      spacing [3];
  wind_t       predicted_wind_q [$];

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic wind_t interpolate(longint px, longint py, longint pz);
    longint pos [3];
    longint base [3];
    longint wt [3][2];
    longint acc [3];
    longint d, s, g, f, w, cx, cy, cz;
    logic [AW-1:0] addr;
    wind_t v, r;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    for (int k = 0; k < 3; k++) begin
      d = pos[k] - origin[k];
      s = (spacing[k] == 0) ? 1 : spacing[k];
      g = floor_div(d * 65536, s);
      base[k] = g >>> 16;
      f = g & 65535;
      wt[k][0] = 65536 - f;
      wt[k][1] = f;
      acc[k] = 0;
    end
    for (int c = 0; c < 8; c++) begin
      cx = base[0] + ((c >> 2) & 1);
      cy = base[1] + ((c >> 1) & 1);
      cz = base[2] + (c & 1);
      if (cx >= 0 && cy >= 0 && cz >= 0 && cx < GridX && cy < GridY && cz < GridZ) begin
        w = (wt[0][(c >> 2) & 1] * wt[1][(c >> 1) & 1]) >> 16;
        w = (w * wt[2][c & 1]) >> 16;
        addr = {cz[ZW-1:0], cy[YW-1:0], cx[XW-1:0]};
        v = grid_mem[addr];
        acc[0] += longint'(v.x) * w;
        acc[1] += longint'(v.y) * w;
        acc[2] += longint'(v.z) * w;
      end
    end
    r.x = sat16(acc[0] >>> 16);
    r.y = sat16(acc[1] >>> 16);
    r.z = sat16(acc[2] >>> 16);
    return r;
  endfunction

  assign pending_o = predicted_wind_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    wind_t got, exp_w;
    logic [AW-1:0] addr;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        origin[k] = 0;
        spacing[k] = 65536;
      end
      fail_count_o <= 0;
    end else begin
      if (valid_i) begin
        got = '{wind_x_i, wind_y_i, wind_z_i};
        if (predicted_wind_q.size() == 0) begin
          $error("result with no request pending: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = predicted_wind_q.pop_front();
          if (got.x !== exp_w.x) $error("wind_x expected %0d got %0d", exp_w.x, got.x);
          if (got.y !== exp_w.y) $error("wind_y expected %0d got %0d", exp_w.y, got.y);
          if (got.z !== exp_w.z) $error("wind_z expected %0d got %0d", exp_w.z, got.z);
          if (got !== exp_w) fail_count_o <= fail_count_o + 1;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:  origin[0] = longint'(signed'(cfg_data_i));
          REG_ORIGIN_Y:  origin[1] = longint'(signed'(cfg_data_i));
          REG_ORIGIN_Z:  origin[2] = longint'(signed'(cfg_data_i));
          REG_SPACING_X: spacing[0] = longint'(cfg_data_i[30:0]);
          REG_SPACING_Y: spacing[1] = longint'(cfg_data_i[30:0]);
          REG_SPACING_Z: spacing[2] = longint'(cfg_data_i[30:0]);
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        addr = {cell_z_i, cell_y_i, cell_x_i};
        case (func_i)
          FUNC_WRITE:  grid_mem[addr] = '{data_x_i, data_y_i, data_z_i};
          FUNC_READ:   predicted_wind_q.push_back(grid_mem[addr]);
          FUNC_INTERP: predicted_wind_q.push_back(interpolate(pos_x_i, pos_y_i, pos_z_i));
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Top of the wind grid sampler testbench: clock, reset, stimulus and verdict.
`default_nettype none
module testbench import wgts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int RandItems = 1600;
  localparam int PhaseCount = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy, valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic [1:0]         func = FUNC_READ;
  logic [3:0]         cell_x = '0, cell_y = '0, cell_z = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] data_x = '0, data_y = '0, data_z = '0;
  logic signed [15:0] wind_x, wind_y, wind_z;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 items_sent = 0;
  longint             org [3];
  longint             spc [3];

  always #5 clk = ~clk;

  wind_grid_trilinear_sampler_core u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .valid_o(valid),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .func_i(func), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .cell_z_i(cell_z), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .data_x_i(data_x), .data_y_i(data_y), .data_z_i(data_z),
    .wind_x_o(wind_x), .wind_y_o(wind_y), .wind_z_o(wind_z)
  );

  wgts_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .valid_i(valid),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .func_i(func), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .cell_z_i(cell_z), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .data_x_i(data_x), .data_y_i(data_y), .data_z_i(data_z),
    .wind_x_i(wind_x), .wind_y_i(wind_y), .wind_z_i(wind_z),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(logic [1:0] f, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                              logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    start <= 1'b1;
    func <= f;
    cell_x <= x; cell_y <= y; cell_z <= z;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    data_x <= dx; data_y <= dy; data_z <= dz;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain outstanding results, then let the block finish any write in flight.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(longint ox, longint oy, longint oz,
                              longint sx, longint sy, longint sz);
    org[0] = ox; org[1] = oy; org[2] = oz;
    spc[0] = sx; spc[1] = sy; spc[2] = sz;
    write_reg(REG_ORIGIN_X, ox[31:0]);
    write_reg(REG_ORIGIN_Y, oy[31:0]);
    write_reg(REG_ORIGIN_Z, oz[31:0]);
    write_reg(REG_SPACING_X, {1'($urandom_range(1)), sx[30:0]});
    write_reg(REG_SPACING_Y, {1'($urandom_range(1)), sy[30:0]});
    write_reg(REG_SPACING_Z, {1'($urandom_range(1)), sz[30:0]});
  endtask

  // Position that lands between -2 and 18 grid units along one axis.
  function automatic logic [31:0] near_grid(int k);
    longint coord, s;
    coord = longint'($urandom_range(20 * 65536)) - 2 * 65536;
    s = (spc[k] == 0) ? 1 : spc[k];
    return 32'(org[k] + ((coord * s) >>> 16));
  endfunction

  task automatic random_request(int pct);
    int sel;
    logic [31:0] px, py, pz;
    sel = $urandom_range(99);
    if (sel < 85) begin
      px = near_grid(0); py = near_grid(1); pz = near_grid(2);
    end else begin
      px = $urandom; py = $urandom; pz = $urandom;
    end
    sel = $urandom_range(99);
    send_request(sel < 50 ? FUNC_INTERP : sel < 75 ? FUNC_READ : sel < 95 ? FUNC_WRITE : FUNC_NOP,
                 4'($urandom), 4'($urandom), 4'($urandom), px, py, pz,
                 16'($urandom), 16'($urandom), 16'($urandom));
    items_sent++;
    idle_gap(pct);
  endtask

  initial begin
    int pct;
    org = '{0, 0, 0};
    spc = '{65536, 65536, 65536};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Fill every cell so no read ever touches an unwritten entry.
    for (int a = 0; a < CellCount; a++) begin
      send_request(FUNC_WRITE, 4'(a), 4'(a >> 4), 4'(a >> 8), '0, '0, '0,
                   16'($urandom), 16'($urandom), 16'($urandom));
    end
    send_request(FUNC_WRITE, 4'd0, 4'd0, 4'd0, '0, '0, '0, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(FUNC_WRITE, 4'd15, 4'd15, 4'd15, '0, '0, '0, 16'h8000, 16'h7fff, 16'h0000);
    send_request(FUNC_READ, 4'd0, 4'd0, 4'd0, '0, '0, '0, '0, '0, '0);
    send_request(FUNC_READ, 4'd15, 4'd15, 4'd15, '0, '0, '0, '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'h0, 32'h0, 32'h0, '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'h000f_0000, 32'h000f_0000, 32'h000f_0000,
                 '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'h000e_8000, 32'h0007_4000, 32'h0000_0001,
                 '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'hffff_8000, 32'h0000_8000, 32'hffff_ffff,
                 '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'hffff_0000, 32'h0010_0000, 32'h0000_ffff,
                 '0, '0, '0);
    send_request(FUNC_NOP, 4'd5, 4'd5, 4'd5, 32'h1234_5678, '0, '0, 16'h1111, '0, '0);
    send_request(FUNC_READ, 4'd5, 4'd5, 4'd5, '0, '0, '0, '0, '0, '0);
    send_request(FUNC_INTERP, '0, '0, '0, 32'h0003_c000, 32'h000b_2000, 32'h0008_0000,
                 '0, '0, '0);
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      case (ph)
        0: load_setting(0, 0, 0, 65536, 65536, 65536);
        1: load_setting(longint'($urandom_range(524288)) - 262144,
                        longint'($urandom_range(524288)) - 262144,
                        longint'($urandom_range(524288)) - 262144,
                        $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                        $urandom_range(16384, 262144));
        2: load_setting(-2147483648, -2147483648, -2147483648,
                        2147483647, 2147483647, 2147483647);
        3: load_setting(2147483647, 2147483647, 2147483647, 1, 1, 1);
        4: load_setting(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
                        longint'(signed'(32'($urandom))), 0, 0, 0);
        default: load_setting(longint'($urandom_range(131072)) - 65536, 32768, -65536,
                              65536, 131072, 98304);
      endcase
      @(posedge clk);
      for (int n = 0; n < RandItems / PhaseCount; n++) begin
        pct = (items_sent < RandItems / 3) ? 23 : (items_sent < 2 * RandItems / 3) ? 71 : 0;
        random_request(pct);
      end
    end
    settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/wgts_pkg.sv
hdl/wgts_div.sv
hdl/wgts_datapath.sv
hdl/wgts_ctrl.sv
hdl/wind_grid_trilinear_sampler_core.sv
tb/sv/wgts_checker.sv
tb/sv/testbench.sv
